[hdl/tacdf_pkg.sv]
// Package: shared constants and state type for the triangle area CDF builder.
`default_nettype none
package tacdf_pkg;
	localparam int MAX_TRIANGLES_DEF = 64;
	localparam int CDF_FRACTION_BITS_DEF = 16;
	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_BITS = 16;
	localparam int AREA_BITS = 33;
	localparam int TOTAL_BITS = 39;
	localparam int INDEX_BITS = 6;
	localparam int CDF_BITS = 17;
	localparam int STORE_DEPTH = 64;
	localparam int ROOT_BITS = 38;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CROSS,
		ST_SQUARE,
		ST_SQRT,
		ST_STORE,
		ST_RD,
		ST_RDWAIT,
		ST_DIV,
		ST_OUT,
		ST_ZERO
	} state_t;
endpackage
`default_nettype wire

[hdl/tacdf_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module tacdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hdl/triangle_area_cdf_builder.sv]
// Top level: triangle area store, running total and CDF emission.
//
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/in_stall   | v0..v2 x/y/z, last_triangle
// out     | output    | out_valid/out_stall | triangle_index, cdf_value, total_area, flags
//
// Each triangle passes in turn through the accept state, the cross-product
// steps, the squaring steps, a 36-step bit-serial square root and a store;
// no new triangle is taken until the last one is stored.
// On last_triangle a setup state starts the emission. A zero total or count gives one
// zero-area result; else each stored area is read from the area RAM (registered read)
// and the running sum up to it is divided by the total with a restoring divider.
// Reset clears the count, total and overflow flag; the area RAM needs no clearing.
// A stalled result holds in the output registers until taken.
`default_nettype none
module triangle_area_cdf_builder
	import tacdf_pkg::*;
#(
	parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
	parameter int CDF_FRACTION_BITS = CDF_FRACTION_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [FIELD_BITS-1:0] v0_x,
	input  wire logic signed [FIELD_BITS-1:0] v0_y,
	input  wire logic signed [FIELD_BITS-1:0] v0_z,
	input  wire logic signed [FIELD_BITS-1:0] v1_x,
	input  wire logic signed [FIELD_BITS-1:0] v1_y,
	input  wire logic signed [FIELD_BITS-1:0] v1_z,
	input  wire logic signed [FIELD_BITS-1:0] v2_x,
	input  wire logic signed [FIELD_BITS-1:0] v2_y,
	input  wire logic signed [FIELD_BITS-1:0] v2_z,
	input  wire logic                         last_triangle,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [INDEX_BITS-1:0]             triangle_index,
	output logic [CDF_BITS-1:0]               cdf_value,
	output logic [TOTAL_BITS-1:0]             total_area,
	output logic                              zero_area,
	output logic                              overflow,
	output logic                              last_result
);
	localparam int EB = COORD_BITS + 1;      // edge width
	localparam int CB = 2 * EB + 1;          // cross component width, signed
	localparam int SB = 2 * CB + 2;          // sum of squares width
	localparam int NB = TOTAL_BITS + CDF_FRACTION_BITS; // dividend width
	localparam int CNTB = INDEX_BITS + 1;
	localparam int QB = $clog2(NB + 1);

	state_t state_q, state_d;

	logic signed [EB-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
	logic signed [CB-1:0] cr_q [3];
	logic [SB-1:0]        sumsq_q;
	logic [1:0]           step_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [SB+1:0]        rrem_q;
	logic [SB-1:0]        rnum_q;
	logic [5:0]           bit_q;
	logic                 last_q;

	logic [TOTAL_BITS-1:0] total_q;
	logic [CNTB-1:0]       count_q;
	logic                  ovf_q;
	logic [CNTB-1:0]       rd_q;
	logic [TOTAL_BITS-1:0] prefix_q;
	logic [NB-1:0]         num_q;
	logic [TOTAL_BITS:0]   drem_q;
	logic [NB-1:0]         quo_q;
	logic [QB-1:0]         dcnt_q;

	logic                  we;
	logic [AREA_BITS-1:0]  wdata, rdata;

	tacdf_ram #(.WIDTH(AREA_BITS), .DEPTH(STORE_DEPTH)) u_area (
		.clk(clk), .we(we), .waddr(count_q[INDEX_BITS-1:0]), .wdata(wdata),
		.raddr(rd_q[INDEX_BITS-1:0]), .rdata(rdata)
	);

	function automatic logic signed [EB-1:0] sx(input logic [FIELD_BITS-1:0] v);
		logic signed [COORD_BITS-1:0] c;
		c = v[COORD_BITS-1:0];
		return EB'(c);
	endfunction

	wire logic in_acc  = in_valid && !in_stall;
	wire logic out_acc = out_valid && !out_stall;
	wire logic room    = (count_q < CNTB'(MAX_TRIANGLES));
	wire logic fin_w   = (rd_q + 1'b1 == count_q);

	// square root trial step
	logic [SB+1:0] trial;
	logic [SB+1:0] rem_sh;
	assign rem_sh = {rrem_q[SB-1:0], rnum_q[SB-1 -: 2]};
	assign trial  = (SB+2)'({root_q[SB/2-1:0], 2'b01});
	// divider trial
	logic [TOTAL_BITS:0] dsh;
	assign dsh = {drem_q[TOTAL_BITS-1:0], num_q[NB-1]};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_acc) state_d = room ? ST_CROSS
				: (last_triangle ? ST_ZERO : ST_IDLE);
			ST_CROSS:  if (step_q == 2'd2) state_d = ST_SQUARE;
			ST_SQUARE: if (step_q == 2'd2) state_d = ST_SQRT;
			ST_SQRT:   if (bit_q == '0) state_d = ST_STORE;
			ST_STORE:  state_d = last_q ? ST_ZERO : ST_IDLE;
			ST_ZERO:   state_d = (total_q == '0 || count_q == '0) ? ST_OUT : ST_RD;
			ST_RD:     state_d = ST_RDWAIT;
			ST_RDWAIT: state_d = ST_DIV;
			ST_DIV:    if (dcnt_q == '0) state_d = ST_OUT;
			ST_OUT:    if (out_acc) state_d = (last_result) ? ST_IDLE : ST_RD;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		we        = (state_q == ST_STORE);
		wdata     = AREA_BITS'(root_q >> 1);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_acc && !room) ovf_q <= 1'b1;
			if (state_q == ST_STORE) begin
				total_q <= total_q + TOTAL_BITS'(wdata);
				count_q <= count_q + 1'b1;
			end
			if (out_acc && last_result) begin
				total_q <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// datapath: cross product, squares, root, division, result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				step_q <= '0;
				last_q <= last_triangle;
				e1x_q <= sx(v1_x) - sx(v0_x);
				e1y_q <= sx(v1_y) - sx(v0_y);
				e1z_q <= sx(v1_z) - sx(v0_z);
				e2x_q <= sx(v2_x) - sx(v0_x);
				e2y_q <= sx(v2_y) - sx(v0_y);
				e2z_q <= sx(v2_z) - sx(v0_z);
				sumsq_q <= '0;
			end
			ST_CROSS: begin
				step_q <= (step_q == 2'd2) ? 2'd0 : step_q + 1'b1;
				case (step_q)
					2'd0:    cr_q[0] <= CB'(e1y_q * e2z_q) - CB'(e1z_q * e2y_q);
					2'd1:    cr_q[1] <= CB'(e1z_q * e2x_q) - CB'(e1x_q * e2z_q);
					default: cr_q[2] <= CB'(e1x_q * e2y_q) - CB'(e1y_q * e2x_q);
				endcase
			end
			ST_SQUARE: begin
				step_q  <= step_q + 1'b1;
				sumsq_q <= sumsq_q + SB'(cr_q[step_q] * cr_q[step_q]);
				rrem_q  <= '0;
				root_q  <= '0;
				bit_q   <= 6'(SB / 2 - 1);
			end
			ST_SQRT: begin
				rnum_q <= (bit_q == 6'(SB / 2 - 1)) ? sumsq_q << 2 : rnum_q << 2;
				if (bit_q == 6'(SB / 2 - 1)) begin
					if (sumsq_q[SB-1 -: 2] != 2'b00) begin
						rrem_q <= (SB+2)'(sumsq_q[SB-1 -: 2]) - 1'b1;
						root_q <= ROOT_BITS'(1);
					end else begin
						rrem_q <= (SB+2)'(sumsq_q[SB-1 -: 2]);
						root_q <= '0;
					end
				end else if (rem_sh >= trial) begin
					rrem_q <= rem_sh - trial;
					root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
				end else begin
					rrem_q <= rem_sh;
					root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
				end
				bit_q <= bit_q - 1'b1;
			end
			ST_ZERO: begin
				rd_q     <= '0;
				prefix_q <= '0;
				triangle_index <= '0;
				cdf_value  <= '0;
				total_area <= '0;
				zero_area  <= 1'b1;
				overflow   <= ovf_q;
				last_result <= 1'b1;
			end
			ST_RDWAIT: begin
				prefix_q <= prefix_q + TOTAL_BITS'(rdata);
				num_q    <= NB'(prefix_q + TOTAL_BITS'(rdata)) << CDF_FRACTION_BITS;
				drem_q   <= '0;
				quo_q    <= '0;
				dcnt_q   <= QB'(NB - 1);
			end
			ST_DIV: begin
				num_q  <= num_q << 1;
				dcnt_q <= dcnt_q - 1'b1;
				if (dsh >= {1'b0, total_q}) begin
					drem_q <= dsh - {1'b0, total_q};
					quo_q  <= {quo_q[NB-2:0], 1'b1};
				end else begin
					drem_q <= dsh;
					quo_q  <= {quo_q[NB-2:0], 1'b0};
				end
				if (dcnt_q == '0) begin
					triangle_index <= rd_q[INDEX_BITS-1:0];
					total_area  <= total_q;
					zero_area   <= 1'b0;
					overflow    <= ovf_q;
					last_result <= fin_w;
					cdf_value   <= fin_w ? CDF_BITS'(NB'(1) << CDF_FRACTION_BITS)
						: CDF_BITS'({quo_q[NB-2:0], (dsh >= {1'b0, total_q})});
				end
			end
			ST_OUT: if (out_acc) rd_q <= rd_q + 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[test/tb_top.sv]
// Testbench for the triangle area CDF builder: directed, capacity and random surfaces.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import tacdf_pkg::*;

	typedef struct packed {
		logic [INDEX_BITS-1:0] idx;
		logic [CDF_BITS-1:0]   cdf;
		logic [TOTAL_BITS-1:0] total;
		logic                  zero;
		logic                  ovf;
		logic                  fin;
	} cdf_entry_t;

	typedef logic signed [FIELD_BITS-1:0] coord_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	coord_t v0_x = '0, v0_y = '0, v0_z = '0;
	coord_t v1_x = '0, v1_y = '0, v1_z = '0;
	coord_t v2_x = '0, v2_y = '0, v2_z = '0;
	logic last_triangle = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [INDEX_BITS-1:0] triangle_index;
	logic [CDF_BITS-1:0] cdf_value;
	logic [TOTAL_BITS-1:0] total_area;
	logic zero_area, overflow, last_result;

	// surface state mirrored from the block
	logic [AREA_BITS-1:0] area_mem [STORE_DEPTH];
	logic [TOTAL_BITS-1:0] area_sum;
	int tri_count;
	logic dropped_seen;

	cdf_entry_t cdf_q [$];
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int surfaces = 0;
	int stall_left = 0;
	bit quiet = 0;

	triangle_area_cdf_builder dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

	// compute one triangle area: half the integer root of the squared cross length
	function automatic logic [AREA_BITS-1:0] tri_area(coord_t p[9]);
		longint e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
		logic [127:0] sq, t;
		logic [63:0] root;
		e1x = longint'(p[3]) - longint'(p[0]);
		e1y = longint'(p[4]) - longint'(p[1]);
		e1z = longint'(p[5]) - longint'(p[2]);
		e2x = longint'(p[6]) - longint'(p[0]);
		e2y = longint'(p[7]) - longint'(p[1]);
		e2z = longint'(p[8]) - longint'(p[2]);
		cx = e1y * e2z - e1z * e2y;
		cy = e1z * e2x - e1x * e2z;
		cz = e1x * e2y - e1y * e2x;
		if (cx < 0) cx = -cx;
		if (cy < 0) cy = -cy;
		if (cz < 0) cz = -cz;
		sq = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
		root = '0;
		for (int b = ROOT_BITS - 1; b >= 0; b--) begin
			t = 128'(root | (64'd1 << b));
			if (t * t <= sq)
				root = t[63:0];
		end
		return AREA_BITS'(root >> 1);
	endfunction

	// store or drop one triangle, and queue the distribution on the last one
	task automatic predict_triangle(coord_t p[9], logic fin);
		cdf_entry_t e;
		logic [63:0] run;
		if (tri_count < MAX_TRIANGLES_DEF) begin
			area_mem[tri_count] = tri_area(p);
			area_sum = area_sum + TOTAL_BITS'(area_mem[tri_count]);
			tri_count++;
		end else begin
			dropped_seen = 1'b1;
		end
		if (!fin)
			return;
		if (area_sum == 0 || tri_count == 0) begin
			e = '{idx: '0, cdf: '0, total: '0, zero: 1'b1, ovf: dropped_seen, fin: 1'b1};
			cdf_q.push_back(e);
		end else begin
			run = '0;
			for (int k = 0; k < tri_count; k++) begin
				run += 64'(area_mem[k]);
				e.idx = INDEX_BITS'(k);
				e.fin = (k + 1 == tri_count);
				e.cdf = e.fin ? CDF_BITS'(1 << CDF_FRACTION_BITS_DEF)
					: CDF_BITS'((run << CDF_FRACTION_BITS_DEF) / 64'(area_sum));
				e.total = area_sum;
				e.zero = 1'b0;
				e.ovf = dropped_seen;
				cdf_q.push_back(e);
			end
		end
		area_sum = '0;
		tri_count = 0;
		dropped_seen = 1'b0;
		surfaces++;
	endtask

	// drive one transaction after a random gap; called and returning at a falling edge
	task automatic send_triangle(coord_t p[9], logic fin);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		{v0_x, v0_y, v0_z} <= {p[0], p[1], p[2]};
		{v1_x, v1_y, v1_z} <= {p[3], p[4], p[5]};
		{v2_x, v2_y, v2_z} <= {p[6], p[7], p[8]};
		last_triangle <= fin;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_triangle(p, fin);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic void rand_triangle(output coord_t p[9], input int span);
		for (int i = 0; i < 9; i++)
			p[i] = (span == 0) ? coord_t'($urandom)
				: coord_t'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		cdf_entry_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			stall_left = quiet ? 0 : $urandom_range(0, 6);
			if (cdf_q.size() == 0) begin
				report_mismatch("unexpected result, index", triangle_index, -1);
			end else begin
				e = cdf_q.pop_front();
				if (triangle_index !== e.idx) report_mismatch("triangle_index", triangle_index, e.idx);
				if (cdf_value !== e.cdf) report_mismatch("cdf_value", cdf_value, e.cdf);
				if (total_area !== e.total) report_mismatch("total_area", total_area, e.total);
				if (zero_area !== e.zero) report_mismatch("zero_area", zero_area, e.zero);
				if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
				if (last_result !== e.fin) report_mismatch("last_result", last_result, e.fin);
			end
		end
	end

	// hold off results for the drawn number of cycles
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// extremes, degenerate triangles, one-triangle and multi-triangle surfaces
	task automatic test_directed();
		coord_t p[9];
		p = '{default: coord_t'(0)};
		send_triangle(p, 1'b1);
		p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh7fff, 16'sh7fff};
		send_triangle(p, 1'b1);
		p = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh7fff, 16'sh8000};
		send_triangle(p, 1'b0);
		p = '{16'sh8000, 16'sh7fff, 16'sh0, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh8000};
		send_triangle(p, 1'b0);
		p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
		send_triangle(p, 1'b1);
		// zero-area triangle inside a surface, a tiny triangle, then a collinear one to close it
		p = '{5, 5, 5, 5, 5, 5, 9, 9, 9};
		send_triangle(p, 1'b0);
		p = '{0, 0, 0, 2, 0, 0, 0, 2, 0};
		send_triangle(p, 1'b0);
		p = '{1, 1, 1, 2, 2, 2, 3, 3, 3};
		send_triangle(p, 1'b1);
		for (int i = 0; i < 6; i++) begin
			rand_triangle(p, 0);
			send_triangle(p, i == 5);
		end
	endtask

	// fill the store, then drop two triangles, the last one carrying the end mark
	task automatic test_capacity();
		coord_t p[9];
		for (int i = 0; i < MAX_TRIANGLES_DEF + 2; i++) begin
			rand_triangle(p, (i % 3 == 0) ? 0 : 300);
			send_triangle(p, i == MAX_TRIANGLES_DEF + 1);
		end
		// a dropped-free zero surface right after
		p = '{default: coord_t'(7)};
		send_triangle(p, 1'b1);
	endtask

	// random surfaces of a few triangles each, with some degenerate ones
	task automatic test_random();
		coord_t p[9];
		int len, sent;
		sent = 0;
		while (sent < 30) begin
			quiet = ($urandom_range(0, 4) == 0);
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 5))
					0: rand_triangle(p, 4);
					1: begin
						rand_triangle(p, 0);
						p[6] = p[3];
						p[7] = p[4];
						p[8] = p[5];
					end
					2: rand_triangle(p, 1000);
					default: rand_triangle(p, 0);
				endcase
				send_triangle(p, i == len - 1);
				sent++;
			end
		end
		quiet = 0;
	endtask

	initial begin
		area_sum = '0;
		tri_count = 0;
		dropped_seen = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_capacity();
		test_random();
		in_valid <= 1'b0;
		wait (cdf_q.size() == 0);
		repeat (300) @(posedge clk);
		$display("Ran %0d triangles in %0d surfaces, checked %0d distribution entries,",
			items_sent, surfaces, results_seen);
		$display("including zero-area surfaces and a store overflow.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
`default_nettype wire
